// ----- sv/fwpc_pkg.sv -----
// Shared types, constants and replacement tables for the four-way cache tag block.
package fwpc_pkg;

  localparam int unsigned SETS             = 32;
  localparam int unsigned LINE_OFFSET_BITS = 5;
  localparam int unsigned WAYS             = 4;
  localparam int unsigned ADDR_BITS        = 32;
  localparam int unsigned INDEX_BITS       = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned TAG_BITS         = ADDR_BITS - LINE_OFFSET_BITS - INDEX_BITS;
  localparam int unsigned WAY_BITS         = 2;
  localparam int unsigned PLRU_BITS        = 3;
  localparam int unsigned COUNT_BITS       = 32;

  typedef logic [INDEX_BITS-1:0]           set_idx_t;
  typedef logic [TAG_BITS-1:0]             tag_t;
  typedef logic [WAYS-1:0][TAG_BITS-1:0]   tag_row_t;
  typedef logic [WAY_BITS-1:0]             way_t;

  // Per-set replacement and status bits, kept together in one memory row.
  typedef struct packed {
    logic [PLRU_BITS-1:0] plru;
    logic [WAYS-1:0]      dirty;
    logic [WAYS-1:0]      valid;
  } meta_t;

  localparam int unsigned META_BITS = $bits(meta_t);
  localparam int unsigned ROW_BITS  = $bits(tag_row_t);

  // Outcome of one lookup.
  typedef struct packed {
    logic hit;
    way_t way;
    logic write_back;
  } lookup_t;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'b01,
    ST_LOOKUP = 2'b10
  } state_e;

  localparam way_t VICTIM_OF_STATE [8] = '{
    2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
  };

  // Indexed by {current state, accessed way}.
  localparam logic [PLRU_BITS-1:0] PLRU_NEXT [32] = '{
    3'd6, 3'd4, 3'd1, 3'd0,
    3'd7, 3'd5, 3'd1, 3'd0,
    3'd6, 3'd4, 3'd3, 3'd2,
    3'd7, 3'd5, 3'd3, 3'd2,
    3'd6, 3'd4, 3'd1, 3'd0,
    3'd7, 3'd5, 3'd1, 3'd0,
    3'd6, 3'd4, 3'd3, 3'd2,
    3'd7, 3'd5, 3'd3, 3'd2
  };

endpackage

// ----- sv/four_way_plru_writeback_cache_tags.sv -----
// Flow: an accepted access reads the set's rows, then looks them up and registers its result.
//   A new access is taken only once that lookup is done; the read-modify-write of the set's
//   tag and status rows through the synchronous memories requires this.
// Reset: asynchronous, active low; clears counters, handshake state and the per-set
//   row-valid flags, so status rows read as zero until first written. No clearing pass.
module four_way_plru_writeback_cache_tags import fwpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ADDR_BITS-1:0]  address_i,
  input  logic                  is_write_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic [WAY_BITS-1:0]   way_o,
  output logic                  write_back_o,
  output logic [COUNT_BITS-1:0] hit_total_o,
  output logic [COUNT_BITS-1:0] miss_total_o,
  output logic [COUNT_BITS-1:0] write_back_total_o
);

  state_e state_q, state_d;

  logic in_accept;
  logic in_lookup;

  // Set index: field above the line offset, folded into range when SETS is not a power of two.
  logic [INDEX_BITS-1:0] idx_field;
  logic [INDEX_BITS:0]   idx_wide;
  set_idx_t              in_set;
  tag_t                  in_tag;

  // Request held across the memory read.
  set_idx_t req_set_q;
  tag_t     req_tag_q;
  logic     req_wr_q;
  logic     meta_vld_q;

  // Per-set flag: status row has been written since reset.
  logic [SETS-1:0] meta_init_q;

  tag_row_t tags_rd;
  tag_row_t tags_wr;
  meta_t    meta_rd;
  meta_t    meta_cur;
  meta_t    meta_wr;
  lookup_t  res;

  logic [COUNT_BITS-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
  logic [COUNT_BITS-1:0] hit_cnt_d, miss_cnt_d, evict_cnt_d;

  logic                  out_valid_q, out_valid_d;
  logic                  hit_q;
  way_t                  way_q;
  logic                  wb_q;

  assign idx_field = address_i[LINE_OFFSET_BITS +: INDEX_BITS];
  assign idx_wide  = {1'b0, idx_field};
  assign in_set    = (idx_wide >= (INDEX_BITS+1)'(SETS))
                   ? INDEX_BITS'(idx_wide - (INDEX_BITS+1)'(SETS))
                   : idx_field;
  assign in_tag    = address_i[ADDR_BITS-1 -: TAG_BITS];

  assign in_lookup  = (state_q == ST_LOOKUP);
  // Hold input during the lookup cycle, or while a result is held by the consumer.
  assign in_stall_o = in_lookup || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACCEPT: if (in_accept) state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = ST_ACCEPT;
      default:   state_d = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCEPT;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the request alongside the memory read.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_set_q  <= in_set;
      req_tag_q  <= in_tag;
      req_wr_q   <= is_write_i;
      meta_vld_q <= meta_init_q[in_set];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_init_q <= '0;
    end else if (in_lookup) begin
      meta_init_q[req_set_q] <= 1'b1;
    end
  end

  // Tag row: all four ways of a set side by side; rewritten only on a fill.
  fwpc_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (in_lookup && !res.hit),
    .waddr_i (req_set_q),
    .wdata_i (tags_wr),
    .re_i    (in_accept),
    .raddr_i (in_set),
    .rdata_o (tags_rd)
  );

  // Status row: PLRU, dirty and valid bits; rewritten on every access.
  fwpc_ram #(
    .WIDTH (META_BITS),
    .DEPTH (SETS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (in_lookup),
    .waddr_i (req_set_q),
    .wdata_i (meta_wr),
    .re_i    (in_accept),
    .raddr_i (in_set),
    .rdata_o (meta_rd)
  );

  // A row never written since reset reads as all zero.
  assign meta_cur = meta_vld_q ? meta_rd : '0;

  fwpc_lookup u_lookup (
    .tag_i      (req_tag_q),
    .is_write_i (req_wr_q),
    .tags_i     (tags_rd),
    .meta_i     (meta_cur),
    .result_o   (res),
    .meta_o     (meta_wr),
    .tags_o     (tags_wr)
  );

  // Advance the running counters; they wrap.
  always_comb begin
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    evict_cnt_d = evict_cnt_q;
    if (in_lookup) begin
      if (res.hit) begin
        hit_cnt_d = hit_cnt_q + 1'b1;
      end else begin
        miss_cnt_d = miss_cnt_q + 1'b1;
      end
      if (res.write_back) begin
        evict_cnt_d = evict_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
    end else begin
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      evict_cnt_q <= evict_cnt_d;
    end
  end

  // Output register: load at lookup, drop once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_lookup) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_lookup) begin
      hit_q <= res.hit;
      way_q <= res.way;
      wb_q  <= res.write_back;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign hit_o              = hit_q;
  assign way_o              = way_q;
  assign write_back_o       = wb_q;
  // Counters only move in the lookup cycle, which also loads the result.
  assign hit_total_o        = hit_cnt_q;
  assign miss_total_o       = miss_cnt_q;
  assign write_back_total_o = evict_cnt_q;

endmodule

// ----- sv/fwpc_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
module fwpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/fwpc_lookup.sv -----
// Tag compare, victim choice and status update for one set.
module fwpc_lookup import fwpc_pkg::*; (
  input  tag_t     tag_i,
  input  logic     is_write_i,
  input  tag_row_t tags_i,
  input  meta_t    meta_i,
  output lookup_t  result_o,
  output meta_t    meta_o,
  output tag_row_t tags_o
);

  logic hit_found;
  way_t hit_way;
  logic free_found;
  way_t free_way;
  way_t sel_way;
  logic evict_dirty;
  logic all_valid;

  // First valid way holding the tag, lowest way wins.
  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (meta_i.valid[w] && (tags_i[w] == tag_i)) begin
        hit_found = 1'b1;
        hit_way   = WAY_BITS'(w);
      end
    end
  end

  // Lowest invalid way.
  always_comb begin
    free_found = 1'b0;
    free_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!meta_i.valid[w]) begin
        free_found = 1'b1;
        free_way   = WAY_BITS'(w);
      end
    end
  end

  assign all_valid = !free_found;

  always_comb begin
    priority if (hit_found) begin
      sel_way = hit_way;
    end else if (!all_valid) begin
      sel_way = free_way;
    end else begin
      sel_way = VICTIM_OF_STATE[meta_i.plru];
    end
  end

  assign evict_dirty = !hit_found && all_valid && meta_i.dirty[sel_way];

  always_comb begin
    meta_o = meta_i;
    tags_o = tags_i;
    if (!hit_found) begin
      meta_o.valid[sel_way] = 1'b1;
      meta_o.dirty[sel_way] = 1'b0;
      tags_o[sel_way]       = tag_i;
    end
    meta_o.plru = PLRU_NEXT[{meta_i.plru, sel_way}];
    if (is_write_i) begin
      meta_o.dirty[sel_way] = 1'b1;
    end
  end

  assign result_o.hit        = hit_found;
  assign result_o.way        = sel_way;
  assign result_o.write_back = evict_dirty;

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the four-way tree-PLRU write-back cache tag block.
module tb import fwpc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 4;
  localparam int unsigned RANDOM_ITEMS = 1236;
  // Slowest correct item: the longest input gap, the longest output stall and the pipeline;
  // the limit covers 1250 such items with a wide margin.
  localparam int unsigned CYCLE_LIMIT  = 600000;
  // Leave room after the last result for a stray late result to show up.
  localparam int unsigned DRAIN_CYCLES = 8;

  // Victim way for each tree state, and the next tree state indexed by {state, way}.
  localparam way_t VICTIM_PICK [8] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3};
  localparam logic [PLRU_BITS-1:0] PLRU_STEP [32] = '{
    3'd6, 3'd4, 3'd1, 3'd0,  3'd7, 3'd5, 3'd1, 3'd0,
    3'd6, 3'd4, 3'd3, 3'd2,  3'd7, 3'd5, 3'd3, 3'd2,
    3'd6, 3'd4, 3'd1, 3'd0,  3'd7, 3'd5, 3'd1, 3'd0,
    3'd6, 3'd4, 3'd3, 3'd2,  3'd7, 3'd5, 3'd3, 3'd2
  };

  // Tags that random accesses reuse so that sets fill, hit and evict often.
  localparam tag_t TAG_POOL [6] = '{
    tag_t'(0), tag_t'(1), tag_t'(2), '1, tag_t'(22'h155555), tag_t'(22'h2aaaaa)
  };

  // What one access should report.
  typedef struct packed {
    logic                  hit;
    way_t                  way;
    logic                  write_back;
    logic [COUNT_BITS-1:0] hit_total;
    logic [COUNT_BITS-1:0] miss_total;
    logic [COUNT_BITS-1:0] write_back_total;
  } access_outcome_t;

  // One directed access; typed rows carry an outcome read straight off the spec.
  typedef struct packed {
    logic [ADDR_BITS-1:0]  addr;
    logic                  wr;
    logic                  typed;
    logic                  hit;
    way_t                  way;
    logic                  write_back;
    logic [COUNT_BITS-1:0] hits;
    logic [COUNT_BITS-1:0] misses;
    logic [COUNT_BITS-1:0] evictions;
  } stim_row_t;

  localparam int unsigned DIRECTED_COUNT = 17;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // Cold miss fills way 0 of set 0, then the same line hits at the far offset.
    '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 2'd0, 1'b0, 32'd0, 32'd1, 32'd0},
    '{32'h0000_001f, 1'b1, 1'b1, 1'b1, 2'd0, 1'b0, 32'd1, 32'd1, 32'd0},
    // All-ones address: set 31, all-ones tag. Dirty it with a write hit.
    '{32'hffff_ffff, 1'b0, 1'b1, 1'b0, 2'd0, 1'b0, 32'd1, 32'd2, 32'd0},
    '{32'hffff_ffe0, 1'b1, 1'b1, 1'b1, 2'd0, 1'b0, 32'd2, 32'd2, 32'd0},
    // Fill the rest of set 31 through the lowest invalid way.
    '{32'h0000_03e0, 1'b1, 1'b1, 1'b0, 2'd1, 1'b0, 32'd2, 32'd3, 32'd0},
    '{32'h0000_07e0, 1'b1, 1'b1, 1'b0, 2'd2, 1'b0, 32'd2, 32'd4, 32'd0},
    '{32'h0000_0be0, 1'b0, 1'b1, 1'b0, 2'd3, 1'b0, 32'd2, 32'd5, 32'd0},
    // Full set: the tree picks the victim, which is the dirty way 0.
    '{32'h0000_0fe0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'h0000_03ff, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'hffff_ffe0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'h0000_07e0, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'h0000_0be0, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'h0000_13e0, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    // Alternating and single-bit patterns across tag, index and offset.
    '{32'haaaa_aaaa, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'h5555_5555, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'h8000_0000, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{32'h7fff_ffff, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd0}
  };

  logic                  clk_i              = 1'b0;
  logic                  rst_ni             = 1'b0;
  logic                  in_valid_i         = 1'b0;
  logic                  in_stall_o;
  logic [ADDR_BITS-1:0]  address_i          = '0;
  logic                  is_write_i         = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i        = 1'b0;
  logic                  hit_o;
  logic [WAY_BITS-1:0]   way_o;
  logic                  write_back_o;
  logic [COUNT_BITS-1:0] hit_total_o;
  logic [COUNT_BITS-1:0] miss_total_o;
  logic [COUNT_BITS-1:0] write_back_total_o;

  // Shadow copy of the cache: tree state, valid, dirty and tags per set, plus counters.
  logic [PLRU_BITS-1:0]  plru_by_set  [SETS];
  logic [WAYS-1:0]       valid_by_set [SETS];
  logic [WAYS-1:0]       dirty_by_set [SETS];
  tag_t                  tag_by_way   [WAYS][SETS];
  logic [COUNT_BITS-1:0] hits_seen    = '0;
  logic [COUNT_BITS-1:0] misses_seen  = '0;
  logic [COUNT_BITS-1:0] evicts_seen  = '0;

  access_outcome_t pending_outcomes [$];
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count    = 0;
  int unsigned     accesses_sent  = 0;
  int unsigned     results_seen   = 0;
  int unsigned     stall_run      = 0;
  // When set, neither side idles: back-to-back accesses that stress same-set read-after-write.
  logic            burst_mode     = 1'b0;

  four_way_plru_writeback_cache_tags dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .address_i          (address_i),
    .is_write_i         (is_write_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .hit_o              (hit_o),
    .way_o              (way_o),
    .write_back_o       (write_back_o),
    .hit_total_o        (hit_total_o),
    .miss_total_o       (miss_total_o),
    .write_back_total_o (write_back_total_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Clear the shadow status bits; tags stay unknown and are read only behind valid.
  initial begin
    for (int s = 0; s < SETS; s++) begin
      plru_by_set[s]  = '0;
      valid_by_set[s] = '0;
      dirty_by_set[s] = '0;
    end
  end

  // Print one line for a failure and count it.
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Look the access up in the shadow cache, update it, and return what it reports.
  function automatic access_outcome_t lookup_and_update(input logic [ADDR_BITS-1:0] addr,
                                                        input logic wr);
    access_outcome_t o;
    set_idx_t        s;
    tag_t            t;
    way_t            w;
    logic            found;
    logic            wb;
    // Fold an index field beyond the last set back into range.
    s     = set_idx_t'(addr[LINE_OFFSET_BITS +: INDEX_BITS] % SETS);
    t     = addr[ADDR_BITS-1 -: TAG_BITS];
    found = 1'b0;
    wb    = 1'b0;
    w     = '0;
    // Compare ways in ascending order; the first valid match wins.
    for (int i = 0; i < WAYS; i++) begin
      if (!found && valid_by_set[s][i] && tag_by_way[i][s] == t) begin
        found = 1'b1;
        w     = way_t'(i);
      end
    end
    if (found) begin
      hits_seen++;
    end else begin
      misses_seen++;
      if (valid_by_set[s] != '1) begin
        // Fill the lowest free way.
        for (int i = WAYS - 1; i >= 0; i--) begin
          if (!valid_by_set[s][i]) begin
            w = way_t'(i);
          end
        end
      end else begin
        // Full set: the tree state names the victim; a dirty one is written back.
        w  = VICTIM_PICK[plru_by_set[s]];
        wb = dirty_by_set[s][w];
        if (wb) begin
          evicts_seen++;
        end
      end
      valid_by_set[s][w] = 1'b1;
      dirty_by_set[s][w] = 1'b0;
      tag_by_way[w][s]   = t;
    end
    plru_by_set[s] = PLRU_STEP[{plru_by_set[s], w}];
    if (wr) begin
      dirty_by_set[s][w] = 1'b1;
    end
    o.hit              = found;
    o.way              = w;
    o.write_back       = wb;
    o.hit_total        = hits_seen;
    o.miss_total       = misses_seen;
    o.write_back_total = evicts_seen;
    return o;
  endfunction

  // Offer one access after a random gap, hold it until taken, then queue its outcome.
  // A typed outcome replaces the predicted one, but the shadow cache still advances.
  task automatic send_access(input logic [ADDR_BITS-1:0] addr, input logic wr,
                             input logic use_typed, input access_outcome_t typed_outcome);
    int unsigned     gap;
    access_outcome_t predicted;
    gap = 0;
    if (!burst_mode) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:      gap = $urandom_range(1, 3);
        6:                     gap = $urandom_range(4, 30);
        default:               gap = 0;
      endcase
    end
    if (gap != 0) begin
      // Drop valid and scramble the idle payload so it is never mistaken for an item.
      in_valid_i <= 1'b0;
      address_i  <= $urandom;
      is_write_i <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i  <= addr;
    is_write_i <= wr;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    predicted = lookup_and_update(addr, wr);
    pending_outcomes.push_back(use_typed ? typed_outcome : predicted);
    accesses_sent++;
  endtask

  // Compare accepted results against the oldest outcome, then pick the next stall.
  always @(posedge clk_i) begin : check_results
    access_outcome_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result arrived with no access outstanding");
        end else begin
          want = pending_outcomes.pop_front();
          if (hit_o !== want.hit)
            report_mismatch($sformatf("hit got %b want %b", hit_o, want.hit));
          if (way_o !== want.way)
            report_mismatch($sformatf("way got %0d want %0d", way_o, want.way));
          if (write_back_o !== want.write_back)
            report_mismatch($sformatf("write_back got %b want %b", write_back_o,
                                      want.write_back));
          if (hit_total_o !== want.hit_total)
            report_mismatch($sformatf("hit_total got %0d want %0d", hit_total_o,
                                      want.hit_total));
          if (miss_total_o !== want.miss_total)
            report_mismatch($sformatf("miss_total got %0d want %0d", miss_total_o,
                                      want.miss_total));
          if (write_back_total_o !== want.write_back_total)
            report_mismatch($sformatf("write_back_total got %0d want %0d",
                                      write_back_total_o, want.write_back_total));
        end
      end
      // Hold stall through a running stretch; otherwise start short or long ones now and then.
      if (stall_run != 0) begin
        stall_run--;
        out_stall_i <= 1'b1;
      end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
        stall_run = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_outcomes.size());
      $display("FAIL four_way_plru_writeback_cache_tags");
      $finish;
    end
  end

  initial begin : stimulus
    access_outcome_t      typed_outcome;
    logic [ADDR_BITS-1:0] addr;
    tag_t                 tag;
    set_idx_t             set_sel;
    // Hold reset, then release it on a clock edge.
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed accesses: extremes, reads and writes, fills, a dirty eviction.
    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      typed_outcome.hit              = DIRECTED_ROWS[r].hit;
      typed_outcome.way              = DIRECTED_ROWS[r].way;
      typed_outcome.write_back       = DIRECTED_ROWS[r].write_back;
      typed_outcome.hit_total        = DIRECTED_ROWS[r].hits;
      typed_outcome.miss_total       = DIRECTED_ROWS[r].misses;
      typed_outcome.write_back_total = DIRECTED_ROWS[r].evictions;
      send_access(DIRECTED_ROWS[r].addr, DIRECTED_ROWS[r].wr, DIRECTED_ROWS[r].typed,
                  typed_outcome);
    end

    // Random accesses: mostly a few hot sets and a small tag pool, so lines hit, fill
    // and get evicted dirty; one in ten is a fully random address.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 63) == 0) begin
        burst_mode = ~burst_mode;
      end
      set_sel = ($urandom_range(0, 3) != 0) ? set_idx_t'($urandom_range(0, 3))
                                            : set_idx_t'($urandom_range(0, SETS - 1));
      tag = ($urandom_range(0, 4) == 0) ? tag_t'($urandom) : TAG_POOL[$urandom_range(0, 5)];
      addr = {tag, set_sel, LINE_OFFSET_BITS'($urandom)};
      if ($urandom_range(0, 9) == 0) begin
        addr = $urandom;
      end
      send_access(addr, 1'($urandom_range(0, 1)), 1'b0, typed_outcome);
    end
    burst_mode = 1'b0;

    // Drop valid, let every outstanding result drain, then watch for strays.
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d accesses and %0d results in %0d cycles:", accesses_sent,
             results_seen, cycle_count);
    $display("  %0d hits, %0d misses, %0d dirty evictions; %0d mismatches", hits_seen,
             misses_seen, evicts_seen, mismatch_count);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("PASS four_way_plru_writeback_cache_tags");
    end else begin
      $display("FAIL four_way_plru_writeback_cache_tags");
    end
    $finish;
  end

endmodule
